[hdl/ssm_pkg.sv]
// Package with the shared sizes, command codes and types of the substring search matcher.
`timescale 1ns / 1ps

package ssm_pkg;

   localparam int MAX_PATTERN     = 16;
   localparam int TEXT_INDEX_BITS = 20;
   localparam int PLEN_W          = $clog2(MAX_PATTERN + 1);
   localparam int CNT_W           = TEXT_INDEX_BITS + 1;
   localparam int MIDX_W          = 21;

   typedef enum logic [1:0] {
      CMD_PATTERN = 2'd0,
      CMD_TEXT    = 2'd1,
      CMD_END     = 2'd2
   } cmd_type;

   typedef struct packed {
      logic pat_shift;
      logic txt_shift;
      logic clear;
   } cell_ctrl_type;

endpackage

[hdl/ssm_req_if.sv]
// Request channel interface: command and character byte with a valid/ready handshake.
`timescale 1ns / 1ps

interface ssm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] char_byte;

   modport source (output valid, output cmd, output char_byte, input ready);
   modport sink   (input valid, input cmd, input char_byte, output ready);
endinterface

[hdl/ssm_rsp_if.sv]
// Response channel interface: search result fields with a valid/ready handshake.
`timescale 1ns / 1ps

interface ssm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [20:0] match_index;
   logic               found;
   logic               is_prefix;
   logic               is_suffix;
   logic               overflowed;

   modport source (output valid, output match_index, output found, output is_prefix,
                   output is_suffix, output overflowed, input ready);
   modport sink   (input valid, input match_index, input found, input is_prefix,
                   input is_suffix, input overflowed, output ready);
endinterface

[hdl/ssm_cell.sv]
// One cell of the compare chain: a pattern byte, a window byte and their comparator.
`timescale 1ns / 1ps

module ssm_cell
   import ssm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          active,
   input  logic [7:0]    pat_in,
   input  logic [7:0]    txt_in,
   output logic [7:0]    pat_out,
   output logic [7:0]    txt_out,
   output logic          eq
);

   logic [7:0] pat_ff;
   logic [7:0] pat_ff_in;
   logic [7:0] txt_ff;
   logic [7:0] txt_ff_in;

   // The pattern is shifted in so that this cell lines up with the window byte it meets.
   always_comb begin
      pat_ff_in = ctrl.pat_shift ? pat_in : pat_ff;
      txt_ff_in = txt_ff;
      if (ctrl.clear) begin
         txt_ff_in = '0;
      end else if (ctrl.txt_shift) begin
         txt_ff_in = txt_in;
      end
   end

   always_ff @(posedge clock) begin
      pat_ff <= pat_ff_in;
      if (reset) begin
         txt_ff <= '0;
      end else begin
         txt_ff <= txt_ff_in;
      end
   end

   // Compare against the byte that this cell is about to take into the window.
   assign eq      = !active || (txt_in == pat_ff);
   assign pat_out = pat_ff;
   assign txt_out = txt_ff;

endmodule

[hdl/substring_search_matcher_core.sv]
// Top level of the streaming substring search matcher built on a chain of compare cells.
`timescale 1ns / 1ps

// Channel   Direction  Transaction carries
// --------  ---------  ----------------------------------------------------------
// req_ch    in         cmd (append pattern, text byte, end of text), char_byte
// rsp_ch    out        match_index, found, is_prefix, is_suffix, overflowed
//
// A new request can be accepted on every clock while no result is stalled.
// The text byte is compared against the whole pattern in the same cycle across the
// chain of MAX_PATTERN cells; an end-of-text result appears in the next cycle.
// Reset is synchronous and clears the length, counters, flags and the text window.
// A result waiting in the output register stalls requests only while rsp_ch.ready is low.

module substring_search_matcher_core
   import ssm_pkg::*;
(
   input  logic clock,
   input  logic reset,
   ssm_req_if.sink   req_ch,
   ssm_rsp_if.source rsp_ch
);

   // Search state.
   logic [PLEN_W-1:0]          plen_ff,    plen_in;
   logic [CNT_W-1:0]           count_ff,   count_in;
   logic [TEXT_INDEX_BITS-1:0] first_ff,   first_in;
   logic                       seen_ff,    seen_in;
   logic                       prefix_ff,  prefix_in;
   logic                       tail_ff,    tail_in;
   logic                       ovf_ff,     ovf_in;

   // Output register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [MIDX_W-1:0]   midx_ff,    midx_in;
   logic                       found_ff,   found_in;
   logic                       is_pre_ff,  is_pre_in;
   logic                       is_suf_ff,  is_suf_in;
   logic                       ovf_out_ff, ovf_out_in;

   logic                       accept;
   logic [CNT_W-1:0]           count_inc;
   logic [CNT_W-1:0]           first_full;
   logic                       hit;
   logic                       all_eq;
   cell_ctrl_type              ctrl;

   logic [7:0]                 pat_link [MAX_PATTERN+1];
   logic [7:0]                 txt_link [MAX_PATTERN+1];
   logic [MAX_PATTERN-1:0]     eq_vec;

   // The request side only waits while an unread result sits in the output register.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign pat_link[0] = req_ch.char_byte;
   assign txt_link[0] = req_ch.char_byte;

   // Cell j holds the window byte j positions back from the newest and the pattern byte
   // that must meet it; only cells below the pattern length take part in the compare.
   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      ssm_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .active  (PLEN_W'(j) < plen_ff),
         .pat_in  (pat_link[j]),
         .txt_in  (txt_link[j]),
         .pat_out (pat_link[j+1]),
         .txt_out (txt_link[j+1]),
         .eq      (eq_vec[j])
      );
   end

   assign all_eq     = &eq_vec;
   assign count_inc  = count_ff + CNT_W'(1);
   assign hit        = (count_inc >= CNT_W'(plen_ff)) && all_eq;
   assign first_full = count_inc - CNT_W'(plen_ff);

   always_comb begin
      plen_in    = plen_ff;
      count_in   = count_ff;
      first_in   = first_ff;
      seen_in    = seen_ff;
      prefix_in  = prefix_ff;
      tail_in    = tail_ff;
      ovf_in     = ovf_ff;
      ctrl       = '0;

      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      midx_in      = midx_ff;
      found_in     = found_ff;
      is_pre_in    = is_pre_ff;
      is_suf_in    = is_suf_ff;
      ovf_out_in   = ovf_out_ff;

      if (accept) begin
         unique case (req_ch.cmd)
            CMD_PATTERN: begin
               // Pattern bytes are taken only before the first text byte.
               if (count_ff == '0) begin
                  if (plen_ff >= PLEN_W'(MAX_PATTERN)) begin
                     ovf_in = 1'b1;
                  end else begin
                     ctrl.pat_shift = 1'b1;
                     plen_in        = plen_ff + PLEN_W'(1);
                  end
               end
            end
            CMD_TEXT: begin
               if (count_ff[TEXT_INDEX_BITS]) begin
                  // The text index range is used up, so the byte is dropped.
                  ovf_in = 1'b1;
               end else begin
                  ctrl.txt_shift = 1'b1;
                  count_in       = count_inc;
                  if (plen_ff != '0) begin
                     tail_in = hit;
                     if (hit) begin
                        if (!seen_ff) begin
                           seen_in  = 1'b1;
                           first_in = first_full[TEXT_INDEX_BITS-1:0];
                        end
                        if (count_inc == CNT_W'(plen_ff)) begin
                           prefix_in = 1'b1;
                        end
                     end
                  end
               end
            end
            CMD_END: begin
               rsp_valid_in = 1'b1;
               ovf_out_in   = ovf_ff;
               if (ovf_ff) begin
                  midx_in   = '1;
                  found_in  = 1'b0;
                  is_pre_in = 1'b0;
                  is_suf_in = 1'b0;
               end else if (plen_ff == '0) begin
                  // An empty pattern matches at the start of any text.
                  midx_in   = '0;
                  found_in  = 1'b1;
                  is_pre_in = 1'b1;
                  is_suf_in = 1'b1;
               end else if (seen_ff) begin
                  midx_in   = MIDX_W'(first_ff);
                  found_in  = 1'b1;
                  is_pre_in = prefix_ff;
                  is_suf_in = tail_ff;
               end else begin
                  midx_in   = '1;
                  found_in  = 1'b0;
                  is_pre_in = 1'b0;
                  is_suf_in = 1'b0;
               end
               // Clear the whole search for the next transaction sequence.
               ctrl.clear = 1'b1;
               plen_in    = '0;
               count_in   = '0;
               first_in   = '0;
               seen_in    = 1'b0;
               prefix_in  = 1'b0;
               tail_in    = 1'b0;
               ovf_in     = 1'b0;
            end
            default: begin
               // The unused command code does nothing.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff      <= '0;
         count_ff     <= '0;
         first_ff     <= '0;
         seen_ff      <= 1'b0;
         prefix_ff    <= 1'b0;
         tail_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         plen_ff      <= plen_in;
         count_ff     <= count_in;
         first_ff     <= first_in;
         seen_ff      <= seen_in;
         prefix_ff    <= prefix_in;
         tail_ff      <= tail_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      midx_ff    <= midx_in;
      found_ff   <= found_in;
      is_pre_ff  <= is_pre_in;
      is_suf_ff  <= is_suf_in;
      ovf_out_ff <= ovf_out_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.match_index = midx_ff;
   assign rsp_ch.found       = found_ff;
   assign rsp_ch.is_prefix   = is_pre_ff;
   assign rsp_ch.is_suffix   = is_suf_ff;
   assign rsp_ch.overflowed  = ovf_out_ff;

endmodule

[hdl/ssm_checker.sv]
// Port-level checker for the substring search matcher and its bind statement.
`timescale 1ns / 1ps

module ssm_checker
   import ssm_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [1:0]        req_cmd,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [20:0] rsp_match_index,
   input logic              rsp_found,
   input logic              rsp_overflowed
);

   // A result stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // An end-of-text transaction produces a result in the next cycle.
   a_end_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == CMD_END) |=> rsp_valid)
      else $error("no response after end of text");

   // Requests wait while a result is stalled in the output register.
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request accepted over a stalled response");

   // A match index is negative exactly when nothing was found.
   a_index_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_found == !rsp_match_index[20]))
      else $error("match index disagrees with found");

   // An overflowed result never reports a match.
   a_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflowed |-> !rsp_found)
      else $error("overflowed result reports a match");

endmodule

bind substring_search_matcher_core ssm_checker u_ssm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .req_cmd         (req_ch.cmd),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_match_index (rsp_ch.match_index),
   .rsp_found       (rsp_ch.found),
   .rsp_overflowed  (rsp_ch.overflowed)
);

[verif/tb_top.sv]
// Self-checking testbench for the streaming substring search matcher core.
`timescale 1ns / 1ps

module tb_top;
   import ssm_pkg::*;

   // Command 3 has no meaning to the block; it must be swallowed without a result.
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int unsigned TEXT_CAP = 1 << TEXT_INDEX_BITS;
   localparam int unsigned RANDOM_ITEMS = 850;

   typedef struct packed {
      logic signed [MIDX_W-1:0] match_index;
      logic                     found;
      logic                     is_prefix;
      logic                     is_suffix;
      logic                     overflowed;
   } search_result_type;

   // One row of the directed table. The row is repeated reps times. Where typed is set,
   // the result of an end-of-text row is the constant in want rather than the prediction.
   typedef struct packed {
      logic [1:0]        op;
      logic [7:0]        ch;
      logic [31:0]       reps;
      logic              typed;
      search_result_type want;
   } stim_row_type;

   // Results that can be read straight off the definition of the search.
   localparam search_result_type RES_START_AND_END = {{MIDX_W{1'b0}}, 4'b1110};
   localparam search_result_type RES_NO_MATCH      = {{MIDX_W{1'b1}}, 4'b0000};
   localparam search_result_type RES_OVERFLOW      = {{MIDX_W{1'b1}}, 4'b0001};

   logic clock;
   logic reset;

   ssm_req_if req_if ();
   ssm_rsp_if rsp_if ();

   substring_search_matcher_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always #5 clock = ~clock;

   // Shadow copy of the search state, updated once per accepted request transaction.
   logic [7:0]                 pat_bytes [MAX_PATTERN];
   int unsigned                pat_len;
   logic [7:0]                 recent_text [MAX_PATTERN];   // Entry 0 holds the newest byte.
   logic [CNT_W-1:0]           text_seen;
   logic [TEXT_INDEX_BITS-1:0] first_hit;
   logic                       hit_seen;
   logic                       starts_with;
   logic                       ends_with;
   logic                       over_cap;

   search_result_type pending_results [$];
   stim_row_type      directed_rows [$];
   int unsigned       error_count;
   int unsigned       random_items;
   logic              sender_burst;

   int unsigned       stall_left;
   int unsigned       stall_roll;
   search_result_type seen_res;
   search_result_type want_res;

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   function automatic void clear_search();
      pat_len     = 0;
      text_seen   = '0;
      first_hit   = '0;
      hit_seen    = 1'b0;
      starts_with = 1'b0;
      ends_with   = 1'b0;
      over_cap    = 1'b0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         pat_bytes[i]   = '0;
         recent_text[i] = '0;
      end
   endfunction

   // Advances the shadow state by one request. Returns 1 when the request yields a result,
   // which is then placed in res.
   function automatic bit step_search(input logic [1:0] op, input logic [7:0] ch,
                                      output search_result_type res);
      bit emitted;
      bit hit;
      emitted = 1'b0;
      res     = '0;
      case (op)
         CMD_PATTERN: begin
            // Pattern bytes are taken only before the first text byte.
            if (text_seen == '0) begin
               if (pat_len >= MAX_PATTERN) begin
                  over_cap = 1'b1;
               end else begin
                  pat_bytes[pat_len] = ch;
                  pat_len++;
               end
            end
         end
         CMD_TEXT: begin
            if (text_seen >= TEXT_CAP) begin
               over_cap = 1'b1;
            end else begin
               for (int i = MAX_PATTERN - 1; i > 0; i--) begin
                  recent_text[i] = recent_text[i-1];
               end
               recent_text[0] = ch;
               text_seen++;
               if (pat_len != 0) begin
                  hit = (text_seen >= pat_len);
                  for (int k = 0; k < pat_len; k++) begin
                     if (recent_text[pat_len-1-k] != pat_bytes[k]) begin
                        hit = 1'b0;
                     end
                  end
                  ends_with = hit;
                  if (hit) begin
                     if (!hit_seen) begin
                        hit_seen  = 1'b1;
                        first_hit = TEXT_INDEX_BITS'(text_seen - CNT_W'(pat_len));
                     end
                     if (text_seen == pat_len) begin
                        starts_with = 1'b1;
                     end
                  end
               end
            end
         end
         CMD_END: begin
            emitted = 1'b1;
            if (over_cap) begin
               res = RES_OVERFLOW;
            end else if (pat_len == 0) begin
               res = RES_START_AND_END;
            end else if (hit_seen) begin
               res.match_index = {1'b0, first_hit};
               res.found       = 1'b1;
               res.is_prefix   = starts_with;
               res.is_suffix   = ends_with;
            end else begin
               res = RES_NO_MATCH;
            end
            clear_search();
         end
         default: begin
         end
      endcase
      return emitted;
   endfunction

   // Most gaps are short; a few are long. In a burst the sender never idles.
   function automatic int unsigned next_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (sender_burst || roll < 55) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // Drives one request transaction from a falling edge, waits for it to be accepted,
   // updates the prediction and then idles for the given gap. It returns on a falling edge.
   task automatic drive_request(input logic [1:0] op, input logic [7:0] ch,
                                input int unsigned gap, input bit typed,
                                input search_result_type typed_res);
      search_result_type predicted;
      req_if.valid     <= 1'b1;
      req_if.cmd       <= op;
      req_if.char_byte <= ch;
      do @(posedge clock); while (!req_if.ready);
      if (step_search(op, ch, predicted)) begin
         pending_results.push_back(typed ? typed_res : predicted);
      end
      @(negedge clock);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic void add_row(input logic [1:0] op, input logic [7:0] ch,
                                   input int unsigned reps, input bit typed,
                                   input search_result_type want);
      stim_row_type row;
      row.op    = op;
      row.ch    = ch;
      row.reps  = reps;
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endfunction

   // Occasionally slips in a request the block must ignore.
   task automatic maybe_noise(input bit text_started);
      if ($urandom_range(0, 39) == 0) begin
         drive_request(CMD_UNUSED, 8'($urandom), next_gap(), 1'b0, '0);
      end else if (text_started && $urandom_range(0, 39) == 0) begin
         drive_request(CMD_PATTERN, 8'($urandom), next_gap(), 1'b0, '0);
      end
   endtask

   // One search: a pattern, a text built to hit the pattern often, then usually end of text.
   // Symbols mostly come from a tiny alphabet so that partial and overlapping matches are common.
   task automatic run_random_search();
      logic [7:0]  pattern_q [$];
      logic [7:0]  text_q [$];
      logic [7:0]  sym_a;
      logic [7:0]  sym_b;
      bit          any_byte;
      int unsigned plen;
      int unsigned tlen;
      int unsigned roll;
      sym_a        = 8'($urandom);
      sym_b        = 8'($urandom);
      any_byte     = ($urandom_range(0, 5) == 0);
      sender_burst = ($urandom_range(0, 4) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         plen = 0;
      end else if (roll < 13) begin
         plen = $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 4);
      end else if (roll < 28) begin
         plen = $urandom_range(5, MAX_PATTERN);
      end else begin
         plen = $urandom_range(1, 4);
      end
      for (int i = 0; i < plen; i++) begin
         pattern_q.push_back(any_byte ? 8'($urandom) : ($urandom_range(0, 1) ? sym_a : sym_b));
      end
      tlen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(0, 24);
      if (plen != 0 && $urandom_range(0, 3) == 0) begin
         text_q = pattern_q;
      end
      while (text_q.size() < tlen) begin
         if (plen != 0 && $urandom_range(0, 7) == 0) begin
            foreach (pattern_q[i]) text_q.push_back(pattern_q[i]);
         end else begin
            text_q.push_back(any_byte ? 8'($urandom) : ($urandom_range(0, 1) ? sym_a : sym_b));
         end
      end
      if (plen != 0 && $urandom_range(0, 3) == 0) begin
         foreach (pattern_q[i]) text_q.push_back(pattern_q[i]);
      end

      foreach (pattern_q[i]) begin
         drive_request(CMD_PATTERN, pattern_q[i], next_gap(), 1'b0, '0);
         random_items++;
         maybe_noise(1'b0);
      end
      foreach (text_q[i]) begin
         drive_request(CMD_TEXT, text_q[i], next_gap(), 1'b0, '0);
         random_items++;
         maybe_noise(1'b1);
      end
      // Now and then the end of text is left out, so that the next search runs into
      // a stale text and its pattern bytes are ignored.
      if ($urandom_range(0, 19) != 0) begin
         drive_request(CMD_END, 8'($urandom), next_gap(), 1'b0, '0);
         random_items++;
      end
   endtask

   // The response side stalls at random: mostly short stalls, a few long ones,
   // and stretches where it always takes the result at once.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 10) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 2);
         end else if (stall_roll < 13) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= $urandom_range(8, 30);
         end else if (stall_roll < 17) begin
            rsp_if.ready <= 1'b1;
            stall_left   <= $urandom_range(20, 60);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Every accepted result is checked field by field against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         seen_res.match_index = rsp_if.match_index;
         seen_res.found       = rsp_if.found;
         seen_res.is_prefix   = rsp_if.is_prefix;
         seen_res.is_suffix   = rsp_if.is_suffix;
         seen_res.overflowed  = rsp_if.overflowed;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result, match_index %0d",
                                      seen_res.match_index));
         end else begin
            want_res = pending_results.pop_front();
            if (seen_res.match_index !== want_res.match_index)
               report_mismatch($sformatf("match_index want %0d got %0d",
                                         want_res.match_index, seen_res.match_index));
            if (seen_res.found !== want_res.found)
               report_mismatch($sformatf("found want %0b got %0b",
                                         want_res.found, seen_res.found));
            if (seen_res.is_prefix !== want_res.is_prefix)
               report_mismatch($sformatf("is_prefix want %0b got %0b",
                                         want_res.is_prefix, seen_res.is_prefix));
            if (seen_res.is_suffix !== want_res.is_suffix)
               report_mismatch($sformatf("is_suffix want %0b got %0b",
                                         want_res.is_suffix, seen_res.is_suffix));
            if (seen_res.overflowed !== want_res.overflowed)
               report_mismatch($sformatf("overflowed want %0b got %0b",
                                         want_res.overflowed, seen_res.overflowed));
         end
      end
   end

   // Watchdog. About a thousand transactions with the longest idle gaps and stalls
   // must finish well before it fires; else the run ends with a failure.
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      int unsigned drain_guard;
      clock            = 1'b0;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.cmd       = CMD_PATTERN;
      req_if.char_byte = '0;
      rsp_if.ready     = 1'b0;
      stall_left       = 0;
      error_count      = 0;
      random_items     = 0;
      sender_burst     = 1'b0;
      drain_guard      = 0;
      clear_search();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty pattern straight after reset: match at 0 with all three flags.
      add_row(CMD_END,     8'h00, 1, 1'b1, RES_START_AND_END);
      // Extreme byte values, pattern equal to the whole text.
      add_row(CMD_PATTERN, 8'h00, 1, 1'b0, '0);
      add_row(CMD_PATTERN, 8'hFF, 1, 1'b0, '0);
      add_row(CMD_TEXT,    8'h00, 1, 1'b0, '0);
      add_row(CMD_TEXT,    8'hFF, 1, 1'b0, '0);
      add_row(CMD_END,     8'hFF, 1, 1'b1, RES_START_AND_END);
      // Pattern longer than the text never matches.
      add_row(CMD_PATTERN, 8'h61, 1, 1'b0, '0);
      add_row(CMD_PATTERN, 8'h62, 1, 1'b0, '0);
      add_row(CMD_PATTERN, 8'h63, 1, 1'b0, '0);
      add_row(CMD_TEXT,    8'h61, 1, 1'b0, '0);
      add_row(CMD_TEXT,    8'h62, 1, 1'b0, '0);
      add_row(CMD_END,     8'h00, 1, 1'b1, RES_NO_MATCH);
      // A pattern byte after text and an unused command are both ignored.
      add_row(CMD_PATTERN, 8'h41, 1, 1'b0, '0);
      add_row(CMD_TEXT,    8'h42, 1, 1'b0, '0);
      add_row(CMD_PATTERN, 8'h42, 1, 1'b0, '0);
      add_row(CMD_UNUSED,  8'h42, 1, 1'b0, '0);
      add_row(CMD_TEXT,    8'h41, 1, 1'b0, '0);
      add_row(CMD_END,     8'h00, 1, 1'b0, '0);
      // Full-length pattern, matched twice in a row.
      add_row(CMD_PATTERN, 8'h80, MAX_PATTERN, 1'b0, '0);
      add_row(CMD_TEXT,    8'h80, MAX_PATTERN + 1, 1'b0, '0);
      add_row(CMD_END,     8'h00, 1, 1'b0, '0);
      // One pattern byte too many.
      add_row(CMD_PATTERN, 8'h55, MAX_PATTERN + 1, 1'b0, '0);
      add_row(CMD_TEXT,    8'h55, 1, 1'b0, '0);
      add_row(CMD_END,     8'h00, 1, 1'b1, RES_OVERFLOW);

      foreach (directed_rows[r]) begin
         for (int unsigned n = 0; n < directed_rows[r].reps; n++) begin
            drive_request(directed_rows[r].op, directed_rows[r].ch, next_gap(),
                          directed_rows[r].typed, directed_rows[r].want);
         end
      end

      while (random_items < RANDOM_ITEMS) begin
         run_random_search();
      end
      // Close any search left open so that every result is drained.
      drive_request(CMD_END, 8'h00, 0, 1'b0, '0);
      req_if.valid <= 1'b0;

      while (pending_results.size() != 0 && drain_guard < 100_000) begin
         @(posedge clock);
         drain_guard++;
      end
      repeat (10) @(posedge clock);
      if (pending_results.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      end

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[substring_search_matcher_core.f]
hdl/ssm_pkg.sv
hdl/ssm_req_if.sv
hdl/ssm_rsp_if.sv
hdl/ssm_cell.sv
hdl/substring_search_matcher_core.sv
hdl/ssm_checker.sv
verif/tb_top.sv
